[src/tssa_pkg.sv]
// Shared constants and types for the touch slider scroll accumulator.
// No dependencies; imported by touch_slider_scroll_accumulator.
`default_nettype none

package tssa_pkg;

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int RUN_W    = 7;
  localparam int SCALE_W  = 4;
  localparam int DIST_W   = 32;
  localparam int DELTA_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHIFT    = 3'd4;

  // Register reset values.
  localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RST  = 16'd150;
  localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RST = 16'd1500;
  localparam logic [SAMPLE_W-1:0] MAX_STEP_RST       = 16'd50;
  localparam logic [RUN_W-1:0]    SETTLE_COUNT_RST   = 7'd100;
  localparam logic [SCALE_W-1:0]  SCALE_SHIFT_RST    = 4'd4;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic signed [DIST_W-1:0] dist_t;

endpackage

`default_nettype wire

[src/touch_slider_scroll_accumulator.sv]
// Touch slider scroll accumulator: touch gating, moving average, step accumulation
// and scaled int8 reporting. Depends on tssa_pkg.
// An accepted request is held in the input register and moves into the output register
// once that register can take its result, then waits there until it is taken. Throughput:
// one sample per cycle; the only stall is a request whose predecessor result is still
// waiting in the output register. Reset (rst, synchronous) clears the window, run
// counter, averages and distance and loads the register defaults.
`default_nettype none

module touch_slider_scroll_accumulator import tssa_pkg::*; #(
  parameter int AVG_DEPTH = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Configuration write port.
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // Sample requests.
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_W-1:0]    sample_value,
  input  wire logic                   report_request,
  // Scroll reports.
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [DELTA_W-1:0]   scroll_delta
);

  // The window sum needs log2 of the depth extra bits; the average shift is
  // floor(log2(AVG_DEPTH)).
  localparam int SUM_W     = SAMPLE_W + $clog2(AVG_DEPTH);
  localparam int AVG_SHIFT = $clog2(AVG_DEPTH + 1) - 1;

  // Configuration registers.
  sample_t              low_threshold;
  sample_t              high_threshold;
  sample_t              max_step;
  logic [RUN_W-1:0]     settle_count;
  logic [SCALE_W-1:0]   scale_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold  <= LOW_THRESHOLD_RST;
      high_threshold <= HIGH_THRESHOLD_RST;
      max_step       <= MAX_STEP_RST;
      settle_count   <= SETTLE_COUNT_RST;
      scale_shift    <= SCALE_SHIFT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW_THRESHOLD:  low_threshold  <= cfg_data;
        REG_HIGH_THRESHOLD: high_threshold <= cfg_data;
        REG_MAX_STEP:       max_step       <= cfg_data;
        REG_SETTLE_COUNT:   settle_count   <= cfg_data[RUN_W-1:0];
        REG_SCALE_SHIFT:    scale_shift    <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register stage. A request only advances when the output register can
  // take its result; a sample without a report request always advances.
  logic     s1_valid;
  sample_t  s1_sample;
  logic     s1_req;
  logic     s1_advance;

  assign s1_advance = s1_valid && (!s1_req || !out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_sample <= sample_value;
      s1_req    <= report_request;
    end
  end

  // Tracking state. The window is a shift line: the sample that leaves the sum
  // is always the one accepted AVG_DEPTH samples ago, at the last tap.
  sample_t              window [AVG_DEPTH];
  logic [SUM_W-1:0]     window_sum;
  sample_t              previous_average;
  logic [RUN_W-1:0]     touch_run;
  dist_t                scroll_distance;

  logic                 touched;
  sample_t              gated_sample;
  logic [RUN_W-1:0]     touch_run_next;
  logic [SUM_W-1:0]     window_sum_next;
  logic [SUM_W-1:0]     avg_wide;
  sample_t              average;
  logic signed [16:0]   step;
  logic signed [17:0]   step_neg;
  logic signed [17:0]   step_limit;
  logic                 step_ok;
  logic signed [32:0]   dist_sum;
  dist_t                dist_sat;
  dist_t                dist_updated;
  logic [DIST_W-1:0]    dist_mag;
  logic [DIST_W-1:0]    dist_scaled;
  logic signed [DELTA_W-1:0] delta_next;

  always_comb begin
    // A reading counts as a touch only strictly between the two thresholds.
    touched      = (s1_sample > low_threshold) && (s1_sample < high_threshold);
    gated_sample = touched ? s1_sample : '0;

    if (!touched) begin
      touch_run_next = '0;
    end else if (touch_run < settle_count) begin
      touch_run_next = touch_run + 1'b1;
    end else begin
      touch_run_next = touch_run;
    end

    // Running sum: add the new sample, drop the oldest one.
    window_sum_next = window_sum - SUM_W'(window[AVG_DEPTH-1])
                      + SUM_W'(gated_sample);
    avg_wide = window_sum_next >> AVG_SHIFT;
    average  = avg_wide[SAMPLE_W-1:0];

    // Step between averages, accepted only when its magnitude is below max_step.
    step       = $signed({1'b0, average}) - $signed({1'b0, previous_average});
    step_neg   = -18'(step);
    step_limit = $signed({2'b00, max_step});
    step_ok    = (18'(step) < step_limit) && (step_neg < step_limit);

    // Saturating 32-bit accumulation.
    dist_sum = 33'(scroll_distance) + 33'(step);
    if (dist_sum[32] != dist_sum[31]) begin
      dist_sat = dist_sum[32] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
    end else begin
      dist_sat = dist_sum[DIST_W-1:0];
    end

    if ((touch_run_next >= settle_count) && step_ok) begin
      dist_updated = dist_sat;
    end else begin
      dist_updated = scroll_distance;
    end

    // Report: divide by 2^scale_shift toward zero by shifting the magnitude,
    // then clamp to the int8 range. The negated most negative value still
    // reads correctly as an unsigned magnitude.
    dist_mag    = dist_updated[DIST_W-1] ? (-dist_updated) : dist_updated;
    dist_scaled = dist_mag >> scale_shift;
    if (dist_updated[DIST_W-1]) begin
      delta_next = (dist_scaled > 32'd128) ? $signed(8'h80) : -$signed(dist_scaled[7:0]);
    end else begin
      delta_next = (dist_scaled > 32'd127) ? $signed(8'h7f) : $signed(dist_scaled[7:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AVG_DEPTH; i++) begin
        window[i] <= '0;
      end
      window_sum       <= '0;
      previous_average <= '0;
      touch_run        <= '0;
      scroll_distance  <= '0;
    end else if (s1_advance) begin
      window[0] <= gated_sample;
      for (int i = 1; i < AVG_DEPTH; i++) begin
        window[i] <= window[i-1];
      end
      window_sum       <= window_sum_next;
      previous_average <= average;
      touch_run        <= touch_run_next;
      // A report clears the distance after it has been sampled.
      scroll_distance  <= s1_req ? '0 : dist_updated;
    end
  end

  // Output register: holds one report until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_req) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_req) begin
      scroll_delta <= delta_next;
    end
  end

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for touch_slider_scroll_accumulator: directed rows, a ramp
// drive, then random touch gestures, all scored against a cycle-free slider model.
// Depends on tssa_pkg and touch_slider_scroll_accumulator.

module tb;
  import tssa_pkg::*;

  localparam int AVG_DEPTH = 8;
  localparam int AVG_SHIFT = $clog2(AVG_DEPTH);
  localparam longint DIST_MAX = 64'sd2147483647;
  localparam longint DIST_MIN = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_STALL = 200;
  // A request passes the input register, then the output register, before it leaves the block.
  localparam int QUIET_CYCLES = 4;
  // Rounds of the ramp-up, drop-out pattern that pile up a large distance.
  localparam int SAT_ROUNDS = 3;

  // Preset selectors used by the directed table.
  localparam logic [2:0] CFG_KEEP   = 3'd0;
  localparam logic [2:0] CFG_OPEN   = 3'd1;
  localparam logic [2:0] CFG_SHUT   = 3'd2;
  localparam logic [2:0] CFG_NARROW = 3'd3;
  localparam logic [2:0] CFG_SAT    = 3'd4;

  typedef struct packed {
    logic [15:0] thr_low;
    logic [15:0] thr_high;
    logic [15:0] max_step;
    logic [6:0]  settle;
    logic [3:0]  scale;
  } cfg_set_t;

  typedef struct packed {
    logic [2:0]  cfg_sel;
    logic [15:0] sample;
    logic        req;
    logic        typed;
    logic [7:0]  delta;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SAMPLE_W-1:0] sample_value = '0;
  logic report_request = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DELTA_W-1:0] scroll_delta;

  touch_slider_scroll_accumulator #(.AVG_DEPTH(AVG_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample_value(sample_value),
    .report_request(report_request),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .scroll_delta(scroll_delta)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Register presets. Slot zero holds the reset values; the others are the extremes
  // that the directed part and the ramp drive need.
  cfg_set_t preset_cfgs [0:4] = '{
    '{LOW_THRESHOLD_RST, HIGH_THRESHOLD_RST, MAX_STEP_RST, SETTLE_COUNT_RST, SCALE_SHIFT_RST},
    '{16'd0, 16'd65535, 16'd65535, 7'd0, 4'd0},
    '{16'd65535, 16'd0, 16'd0, 7'd127, 4'd15},
    '{16'd1000, 16'd1001, 16'd65535, 7'd0, 4'd0},
    '{16'd0, 16'd65535, 16'd4097, 7'd0, 4'd15}
  };

  // Directed stimulus. A typed delta is given only where it is obvious: while the run
  // counter cannot reach the settle count, every report must be zero.
  sample_row_t directed_rows [0:21] = '{
    // Reset settings: settle count 100 is never reached here.
    '{CFG_KEEP,   16'd0,     1'b1, 1'b1, 8'd0},
    '{CFG_KEEP,   16'd65535, 1'b1, 1'b1, 8'd0},
    '{CFG_KEEP,   16'd151,   1'b0, 1'b0, 8'd0},
    '{CFG_KEEP,   16'd150,   1'b1, 1'b1, 8'd0},
    '{CFG_KEEP,   16'd1500,  1'b1, 1'b1, 8'd0},
    '{CFG_KEEP,   16'd1499,  1'b1, 1'b1, 8'd0},
    // Wide-open window, zero settle count, no step limit, no scaling.
    '{CFG_OPEN,   16'd65535, 1'b0, 1'b0, 8'd0},
    '{CFG_OPEN,   16'd65534, 1'b1, 1'b0, 8'd0},
    '{CFG_KEEP,   16'd0,     1'b0, 1'b0, 8'd0},
    '{CFG_KEEP,   16'd0,     1'b0, 1'b0, 8'd0},
    '{CFG_KEEP,   16'd0,     1'b0, 1'b0, 8'd0},
    '{CFG_KEEP,   16'd0,     1'b0, 1'b0, 8'd0},
    '{CFG_KEEP,   16'd0,     1'b0, 1'b0, 8'd0},
    '{CFG_KEEP,   16'd0,     1'b0, 1'b0, 8'd0},
    '{CFG_KEEP,   16'd0,     1'b0, 1'b0, 8'd0},
    '{CFG_KEEP,   16'd0,     1'b1, 1'b0, 8'd0},
    // Thresholds crossed the far way round: nothing is a touch, nothing accumulates.
    '{CFG_SHUT,   16'd65535, 1'b1, 1'b1, 8'd0},
    '{CFG_KEEP,   16'd0,     1'b1, 1'b1, 8'd0},
    '{CFG_KEEP,   16'd32768, 1'b1, 1'b1, 8'd0},
    // Thresholds one apart: no touch, but zero settle lets the draining window move.
    '{CFG_NARROW, 16'd1000,  1'b0, 1'b0, 8'd0},
    '{CFG_KEEP,   16'd1001,  1'b1, 1'b0, 8'd0},
    '{CFG_KEEP,   16'd65535, 1'b1, 1'b0, 8'd0}
  };

  // Slider model state and its copy of the registers.
  logic [15:0] low_thr, high_thr, step_limit;
  logic [6:0]  settle_len;
  logic [3:0]  shift_amt;
  logic [15:0] win_samples [AVG_DEPTH];
  logic [AVG_SHIFT-1:0] win_pos;
  logic [18:0] win_total;
  logic [15:0] last_avg;
  logic [6:0]  touch_len;
  longint      scroll_dist;

  logic signed [7:0] pending_deltas [$];
  int mismatches = 0;
  int cycle_count = 0;
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  logic stall_req = 1'b0;
  logic stall_ack;
  // Typed expectation that travels with the request currently offered.
  logic row_typed = 1'b0;
  logic signed [7:0] row_delta = '0;

  function automatic void clear_slider();
    low_thr = LOW_THRESHOLD_RST;
    high_thr = HIGH_THRESHOLD_RST;
    step_limit = MAX_STEP_RST;
    settle_len = SETTLE_COUNT_RST;
    shift_amt = SCALE_SHIFT_RST;
    for (int i = 0; i < AVG_DEPTH; i++) win_samples[i] = '0;
    win_pos = '0;
    win_total = '0;
    last_avg = '0;
    touch_len = '0;
    scroll_dist = 0;
  endfunction

  // Advances the slider model by one sample; delta is the report it makes, if asked.
  function automatic void advance_slider(input logic [15:0] s, input logic req,
                                         output logic signed [7:0] delta);
    logic [15:0] v;
    logic [15:0] avg;
    longint step, q;
    v = s;
    if (!(s > low_thr && s < high_thr)) begin
      v = '0;
      touch_len = '0;
    end else if (touch_len < settle_len) begin
      touch_len = touch_len + 7'd1;
    end
    win_total = win_total - win_samples[win_pos] + v;
    win_samples[win_pos] = v;
    win_pos = win_pos + 1'b1;
    avg = 16'(win_total >> AVG_SHIFT);
    if (touch_len >= settle_len) begin
      step = longint'(avg) - longint'(last_avg);
      if (step < longint'(step_limit) && -step < longint'(step_limit)) begin
        scroll_dist = scroll_dist + step;
        if (scroll_dist > DIST_MAX) scroll_dist = DIST_MAX;
        if (scroll_dist < DIST_MIN) scroll_dist = DIST_MIN;
      end
    end
    last_avg = avg;
    delta = '0;
    if (req) begin
      // The scale divides the magnitude, so the quotient truncates toward zero.
      if (scroll_dist < 0) q = -((-scroll_dist) >> shift_amt);
      else q = scroll_dist >> shift_amt;
      if (q > 127) q = 127;
      if (q < -128) q = -128;
      delta = q[7:0];
      scroll_dist = 0;
    end
  endfunction

  task automatic note_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Scoreboard: reports are checked before new requests are modeled, so a report
  // can never be matched against an expectation raised on the same edge.
  always @(posedge clk) begin
    logic signed [7:0] predicted;
    logic signed [7:0] want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_deltas.size() == 0) begin
          note_mismatch($sformatf("unexpected report scroll_delta=%0d", scroll_delta));
        end else begin
          want = pending_deltas.pop_front();
          if (scroll_delta !== want)
            note_mismatch($sformatf("scroll_delta=%0d, expected %0d", scroll_delta, want));
        end
      end
      if (in_valid && in_ready) begin
        advance_slider(sample_value, report_request, predicted);
        if (report_request) pending_deltas.push_back(row_typed ? row_delta : predicted);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL touch_slider_scroll_accumulator");
      $finish;
    end
  end

  // Report side. A long hold-off asked for by the stimulus is counted out here, while
  // the sender keeps offering requests; otherwise ready drops at the current rate.
  initial begin
    stall_ack = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req != stall_ack) begin
        out_ready = 1'b0;
        repeat (LONG_STALL) @(negedge clk);
        stall_ack = stall_req;
      end
      out_ready = ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Offers one request, with random idle cycles ahead of it, and returns at the falling
  // edge after it was taken. Valid is left high so a following request keeps it high.
  task automatic push_sample(input logic [15:0] s, input logic req,
                             input logic typed = 1'b0, input logic signed [7:0] want = '0);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sample_value = s;
    report_request = req;
    row_typed = typed;
    row_delta = want;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Holds off the sender until every report is back, then lets the pipeline empty,
  // since requests without a report may still be in flight.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_deltas.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_LOW_THRESHOLD:  low_thr = val;
      REG_HIGH_THRESHOLD: high_thr = val;
      REG_MAX_STEP:       step_limit = val;
      REG_SETTLE_COUNT:   settle_len = val[6:0];
      REG_SCALE_SHIFT:    shift_amt = val[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input cfg_set_t c);
    wait_idle();
    write_reg(REG_LOW_THRESHOLD, c.thr_low);
    write_reg(REG_HIGH_THRESHOLD, c.thr_high);
    write_reg(REG_MAX_STEP, c.max_step);
    write_reg(REG_SETTLE_COUNT, {9'd0, c.settle});
    write_reg(REG_SCALE_SHIFT, {12'd0, c.scale});
  endtask

  // Mostly sane settings, now and then anything the registers hold.
  task automatic shuffle_config();
    cfg_set_t c;
    int h;
    c.thr_low = ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(2000));
    h = int'(c.thr_low) + $urandom_range(20000, 50);
    if (h > 65535) h = 65535;
    c.thr_high = ($urandom_range(5) == 0) ? 16'($urandom_range(65535)) : h[15:0];
    c.max_step = ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(300));
    c.settle = ($urandom_range(4) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(12));
    c.scale = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(4));
    apply_config(c);
  endtask

  // Finger strokes: runs of touches that wander inside the thresholds, up to 40 samples
  // longer than the settle count, with the odd glitch; between them, releases and noise.
  task automatic send_strokes(input int n_items);
    int sent, run_len, pos, lo, hi, jitter;
    logic [15:0] s;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 7 && int'(low_thr) + 1 < int'(high_thr)) begin
        lo = int'(low_thr) + 1;
        hi = int'(high_thr) - 1;
        run_len = $urandom_range(int'(settle_len) + 40, 1);
        pos = $urandom_range(hi, lo);
        case ($urandom_range(2))
          0: jitter = 8;
          1: jitter = 96;
          default: jitter = 2048;
        endcase
        repeat (run_len) begin
          pos = pos + int'($urandom_range(2 * jitter)) - jitter;
          if (pos < lo) pos = lo;
          if (pos > hi) pos = hi;
          s = pos[15:0];
          if ($urandom_range(39) == 0) s = 16'($urandom_range(65535));
          push_sample(s, $urandom_range(5) == 0);
          sent++;
        end
      end else begin
        repeat ($urandom_range(8, 1)) begin
          case ($urandom_range(3))
            0: s = 16'd0;
            1: s = 16'hffff;
            default: s = 16'($urandom_range(65535));
          endcase
          push_sample(s, $urandom_range(3) == 0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int waited;
    clear_slider();
    repeat (5) @(negedge clk);
    rst = 1'b0;

    send_gap_pct = 30;
    recv_gap_pct = 81;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_sel != CFG_KEEP)
        apply_config(preset_cfgs[directed_rows[i].cfg_sel]);
      push_sample(directed_rows[i].sample, directed_rows[i].req,
                  directed_rows[i].typed, directed_rows[i].delta);
    end

    // Build up a large distance. Rising steps of about 4096 are taken, the drop back
    // to zero (about 8192 per sample) is not, so each round nets one full-scale
    // average; the report at a scale of 15 checks the shift of a large magnitude.
    apply_config(preset_cfgs[CFG_SAT]);
    repeat (AVG_DEPTH - 1) push_sample(16'd0, 1'b0);
    push_sample(16'd0, 1'b1);
    repeat (SAT_ROUNDS) begin
      repeat (AVG_DEPTH) push_sample(16'd32767, 1'b0);
      repeat (AVG_DEPTH) push_sample(16'd65534, 1'b0);
      repeat (AVG_DEPTH) push_sample(16'd0, 1'b0);
    end
    repeat (AVG_DEPTH) push_sample(16'd32767, 1'b0);
    push_sample(16'd32767, 1'b1);

    send_gap_pct = 30;
    recv_gap_pct = 81;
    repeat (3) begin
      shuffle_config();
      send_strokes(160);
    end

    send_gap_pct = 81;
    recv_gap_pct = 30;
    repeat (3) begin
      shuffle_config();
      send_strokes(160);
    end

    // Back-pressure: the report side stops for a long stretch while report requests
    // keep coming, so the block fills and holds off its input.
    send_gap_pct = 0;
    recv_gap_pct = 0;
    stall_req = ~stall_req;
    repeat (30) push_sample(16'($urandom_range(65535)), 1'b1);

    repeat (3) begin
      shuffle_config();
      send_strokes(160);
    end

    in_valid = 1'b0;
    waited = 0;
    while (pending_deltas.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (QUIET_CYCLES * 2) @(negedge clk);
    if (pending_deltas.size() != 0)
      note_mismatch($sformatf("%0d reports never arrived", pending_deltas.size()));

    if (mismatches == 0) begin
      $display("PASS touch_slider_scroll_accumulator");
    end else begin
      $display("FAIL touch_slider_scroll_accumulator");
    end
    $finish;
  end

endmodule
